/* rtl/core/frb_pkg.sv */
// Shared types and constants of the framed ring buffer.
// Command codes, register indexes, item structs and the control FSM states.
// No dependencies.
package frb_pkg;

   // Field widths of the item channels
   localparam int CMD_W = 3;
   localparam int REQ_W = 17;
   localparam int LEN_W = 17;
   localparam int OFS_W = 16;
   localparam int UND_W = 16;
   localparam int MARK_W = 17;
   localparam int CSR_ADDR_W = 1;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_RESERVE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_COMMIT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FETCH = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DRAIN = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd4;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_PLAY_MARK = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_EMPTY_MARK = 1'd1;

   // Reset values of the watermarks
   localparam logic [MARK_W-1:0] PLAY_MARK_RESET = 17'd16384;
   localparam logic [MARK_W-1:0] EMPTY_MARK_RESET = 17'd0;

   // Silence clip: 256 stereo 16-bit samples
   localparam logic [LEN_W-1:0] SILENCE_BYTES = 17'(256 * 2 * 2);

   // Commit payloads must be 4-byte aligned
   localparam logic [1:0] ALIGN_MASK = 2'd3;

   // One command item
   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [REQ_W-1:0] request_bytes;
   } cmd_item_type;

   // One result item
   typedef struct packed {
      logic              accepted;
      logic [LEN_W-1:0]  length_bytes;
      logic [OFS_W-1:0]  data_offset;
      logic              silence;
      logic [UND_W-1:0]  underrun_count;
      logic              empty_res;
      logic [LEN_W-1:0]  bytes_in_use;
   } rsp_item_type;

   // Control sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } ctrl_state_type;

endpackage

/* rtl/core/framed_ring_buffer_with_watermarks.sv */
// Top level of the framed ring buffer: stream handshakes, watermark
// registers, command sequencer. Depends on frb_pkg, frb_ram, frb_books.
//
// Usage:
//   Commands (reserve, commit, fetch, drain, flush) enter on the req_
//   stream; the command code travels in req_tuser, the byte count in
//   req_tdata. Every command gives exactly one result item on rsp_.
//   The user must write the watermarks through csr_ only while no command
//   is in flight; the block itself does not enforce it. The accepting edge
//   captures the item and reads the frame length FIFO RAM at its head; the
//   sequencer then moves to ST_EXEC, and once the output register is free
//   it updates the books, loads the output register and raises rsp_tvalid.
//   A new item is accepted only in ST_IDLE, after the previous item has been
//   executed; the FIFO RAM read is registered ahead of the update.
//   A new item is accepted while a result still waits in the output
//   register; while that result is not taken, the new item waits in ST_EXEC
//   and its update is held until rsp_tready.
//   Reset: all books cleared, watermarks back to 16384 (play) and 0 (empty),
//   no result pending. The FIFO RAM is not cleared; only written entries
//   are ever read.
module framed_ring_buffer_with_watermarks
   import frb_pkg::*;
#(
   parameter int BUFFER_BYTES = 65536,
   parameter int HEADER_BYTES = 8,
   parameter int MAX_FRAMES = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   // command items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // [16:0] request_bytes, zero pad
   input  logic [CMD_W-1:0]      req_tuser,   // [2:0] command
   // result items
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] accepted, [17:1] length_bytes, [33:18] data_offset, [34] silence,
   // [50:35] underrun_count, [51] empty_res, [68:52] bytes_in_use, zero pad
   output logic [71:0]           rsp_tdata,
   // configuration writes
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [MARK_W-1:0]     csr_wr_data
);

   localparam int USE_W = $clog2(BUFFER_BYTES + 1);
   localparam int FIDX_W = $clog2(MAX_FRAMES);

   ctrl_state_type state_ff, state_in;
   cmd_item_type   item_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_item_type   rsp_item_ff;
   rsp_item_type   result;
   logic           exec;
   logic           take_item;
   logic [MARK_W-1:0] play_mark_ff, empty_mark_ff;

   logic              fifo_wr_en;
   logic [FIDX_W-1:0] fifo_wr_addr, fifo_rd_addr;
   logic [USE_W-1:0]  fifo_wr_data, fifo_rd_data;

   // Watermark registers
   always_ff @(posedge clock) begin
      if (reset) begin
         play_mark_ff <= PLAY_MARK_RESET;
         empty_mark_ff <= EMPTY_MARK_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            REG_PLAY_MARK:  play_mark_ff <= csr_wr_data;
            REG_EMPTY_MARK: empty_mark_ff <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // Sequencer: take an item, then execute once the output register is free
   always_comb begin
      state_in = state_ff;
      req_tready = 1'b0;
      exec = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_tready) begin
               exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      take_item = req_tvalid && req_tready;
      rsp_valid_in = exec || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Captured item and output register
   always_ff @(posedge clock) begin
      if (take_item) begin
         item_ff.command <= req_tuser;
         item_ff.request_bytes <= req_tdata[REQ_W-1:0];
      end
      if (exec) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {3'b000,
                       rsp_item_ff.bytes_in_use,
                       rsp_item_ff.empty_res,
                       rsp_item_ff.underrun_count,
                       rsp_item_ff.silence,
                       rsp_item_ff.data_offset,
                       rsp_item_ff.length_bytes,
                       rsp_item_ff.accepted};

   // Bookkeeping
   frb_books #(
      .BUFFER_BYTES(BUFFER_BYTES),
      .HEADER_BYTES(HEADER_BYTES),
      .MAX_FRAMES(MAX_FRAMES)
   ) u_books (
      .clock(clock),
      .reset(reset),
      .exec(exec),
      .item(item_ff),
      .play_mark(play_mark_ff),
      .empty_mark(empty_mark_ff),
      .result(result),
      .fifo_rd_addr(fifo_rd_addr),
      .fifo_rd_data(fifo_rd_data),
      .fifo_wr_en(fifo_wr_en),
      .fifo_wr_addr(fifo_wr_addr),
      .fifo_wr_data(fifo_wr_data)
   );

   // Frame length FIFO storage
   frb_ram #(
      .WIDTH(USE_W),
      .DEPTH(MAX_FRAMES)
   ) u_len_ram (
      .clock(clock),
      .wr_en(fifo_wr_en),
      .wr_addr(fifo_wr_addr),
      .wr_data(fifo_wr_data),
      .rd_addr(fifo_rd_addr),
      .rd_data(fifo_rd_data)
   );

endmodule

/* rtl/core/frb_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module frb_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/core/frb_books.sv */
// Bookkeeping of the frame ring: offsets, bytes in use, watermark state,
// underrun counter and the pointers of the frame length FIFO held in RAM.
// Depends on frb_pkg.
module frb_books
   import frb_pkg::*;
#(
   parameter int BUFFER_BYTES = 65536,
   parameter int HEADER_BYTES = 8,
   parameter int MAX_FRAMES = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            exec,
   input  cmd_item_type                    item,
   input  logic [MARK_W-1:0]               play_mark,
   input  logic [MARK_W-1:0]               empty_mark,
   output rsp_item_type                    result,
   output logic [$clog2(MAX_FRAMES)-1:0]   fifo_rd_addr,
   input  logic [$clog2(BUFFER_BYTES+1)-1:0] fifo_rd_data,
   output logic                            fifo_wr_en,
   output logic [$clog2(MAX_FRAMES)-1:0]   fifo_wr_addr,
   output logic [$clog2(BUFFER_BYTES+1)-1:0] fifo_wr_data
);

   localparam int USE_W = $clog2(BUFFER_BYTES + 1);
   localparam int POS_W = $clog2(BUFFER_BYTES);
   localparam int SUM_W = USE_W + 1;
   localparam int FIDX_W = $clog2(MAX_FRAMES);
   localparam int FCNT_W = $clog2(MAX_FRAMES + 1);

   // Ring offset advance, the sum stays below twice the ring size
   function automatic logic [POS_W-1:0] ring_add(input logic [POS_W-1:0] pos,
                                                 input logic [USE_W-1:0] n);
      logic [SUM_W-1:0] s;
      s = SUM_W'(pos) + SUM_W'(n);
      if (s >= SUM_W'(BUFFER_BYTES)) begin
         s = s - SUM_W'(BUFFER_BYTES);
      end
      return s[POS_W-1:0];
   endfunction

   function automatic logic [FIDX_W-1:0] idx_next(input logic [FIDX_W-1:0] idx);
      return (idx == FIDX_W'(MAX_FRAMES - 1)) ? '0 : idx + 1'b1;
   endfunction

   logic [POS_W-1:0]  wr_pos_ff, wr_pos_in;
   logic [POS_W-1:0]  rd_pos_ff, rd_pos_in;
   logic [USE_W-1:0]  used_ff, used_in;
   logic [USE_W-1:0]  playing_ff, playing_in;
   logic              empty_mode_ff, empty_mode_in;
   logic [UND_W-1:0]  underruns_ff, underruns_in;
   logic [FIDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [FIDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [FCNT_W-1:0] count_ff, count_in;

   logic [31:0]       used32, room32, frame32, req32, after_free32;
   logic [USE_W-1:0]  after_free;
   logic [MARK_W-1:0] mark;
   logic              reserve_ok, commit_ok, fetch_ok;
   logic [POS_W-1:0]  ofs_out;
   logic [31:0]       ofs32;
   logic [LEN_W-1:0]  len_out;
   logic              acc_out, sil_out;

   // Space checks for reserve and commit, level check for fetch
   always_comb begin
      used32 = 32'(used_ff);
      req32 = 32'(item.request_bytes);
      room32 = 32'(BUFFER_BYTES) - used32;
      frame32 = req32 + 32'(HEADER_BYTES);
      reserve_ok = (used32 + 32'(HEADER_BYTES) <= 32'(BUFFER_BYTES)) &&
                   (req32 <= room32 - 32'(HEADER_BYTES));
      commit_ok = (item.request_bytes != '0) &&
                  ((item.request_bytes[1:0] & ALIGN_MASK) == 2'd0) &&
                  (frame32 <= room32) &&
                  (count_ff != FCNT_W'(MAX_FRAMES));
      after_free = used_ff - playing_ff;
      after_free32 = 32'(after_free);
      mark = empty_mode_ff ? empty_mark : play_mark;
      fetch_ok = (after_free32 > 32'(mark)) && (count_ff != '0);
   end

   // Next state and result of one command
   always_comb begin
      wr_pos_in = wr_pos_ff;
      rd_pos_in = rd_pos_ff;
      used_in = used_ff;
      playing_in = playing_ff;
      empty_mode_in = empty_mode_ff;
      underruns_in = underruns_ff;
      rd_idx_in = rd_idx_ff;
      wr_idx_in = wr_idx_ff;
      count_in = count_ff;
      fifo_wr_en = 1'b0;
      acc_out = 1'b0;
      sil_out = 1'b0;
      len_out = '0;
      ofs_out = '0;
      unique case (item.command)
         CMD_RESERVE: begin
            if (reserve_ok) begin
               acc_out = 1'b1;
               len_out = LEN_W'(room32 - 32'(HEADER_BYTES));
               ofs_out = ring_add(wr_pos_ff, USE_W'(HEADER_BYTES));
            end
         end
         CMD_COMMIT: begin
            if (commit_ok) begin
               acc_out = 1'b1;
               fifo_wr_en = exec;
               wr_idx_in = idx_next(wr_idx_ff);
               count_in = count_ff + 1'b1;
               wr_pos_in = ring_add(wr_pos_ff, USE_W'(frame32));
               used_in = used_ff + USE_W'(frame32);
            end
         end
         CMD_FETCH: begin
            used_in = after_free;
            playing_in = '0;
            if (fetch_ok) begin
               acc_out = 1'b1;
               empty_mode_in = 1'b1;
               rd_idx_in = idx_next(rd_idx_ff);
               count_in = count_ff - 1'b1;
               ofs_out = ring_add(rd_pos_ff, USE_W'(HEADER_BYTES));
               rd_pos_in = ring_add(rd_pos_ff, fifo_rd_data);
               playing_in = fifo_rd_data;
               len_out = LEN_W'(32'(fifo_rd_data) - 32'(HEADER_BYTES));
            end else begin
               if (empty_mode_ff && (underruns_ff != '1)) begin
                  underruns_in = underruns_ff + 1'b1;
               end
               empty_mode_in = 1'b0;
               len_out = SILENCE_BYTES;
               sil_out = 1'b1;
            end
         end
         CMD_DRAIN: begin
            empty_mode_in = 1'b1;
         end
         CMD_FLUSH: begin
            wr_pos_in = '0;
            rd_pos_in = '0;
            used_in = '0;
            playing_in = '0;
            empty_mode_in = 1'b0;
            underruns_in = '0;
            rd_idx_in = '0;
            wr_idx_in = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   // Result fields, masked to the channel widths
   always_comb begin
      ofs32 = 32'(ofs_out);
      result.accepted = acc_out;
      result.length_bytes = len_out;
      result.data_offset = ofs32[OFS_W-1:0];
      result.silence = sil_out;
      result.underrun_count = underruns_in;
      result.empty_res = (used_in == '0);
      result.bytes_in_use = LEN_W'(32'(used_in));
   end

   // FIFO RAM ports
   assign fifo_rd_addr = rd_idx_ff;
   assign fifo_wr_addr = wr_idx_ff;
   assign fifo_wr_data = USE_W'(frame32);

   // State registers, updated once per executed command
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff <= '0;
         rd_pos_ff <= '0;
         used_ff <= '0;
         playing_ff <= '0;
         empty_mode_ff <= 1'b0;
         underruns_ff <= '0;
         rd_idx_ff <= '0;
         wr_idx_ff <= '0;
         count_ff <= '0;
      end else if (exec) begin
         wr_pos_ff <= wr_pos_in;
         rd_pos_ff <= rd_pos_in;
         used_ff <= used_in;
         playing_ff <= playing_in;
         empty_mode_ff <= empty_mode_in;
         underruns_ff <= underruns_in;
         rd_idx_ff <= rd_idx_in;
         wr_idx_ff <= wr_idx_in;
         count_ff <= count_in;
      end
   end

endmodule
